### sv/adsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the assist demand slew controller.
package adsc_pkg;

	localparam int NORM_FRAC_BITS_DEF = 16;

	localparam logic [31:0] RST_ASSIST_RANGE = 32'd183500950;
	localparam logic [15:0] RST_VEL_FS       = 16'd180;
	localparam logic [19:0] RST_ACC_FS       = 20'd2000;
	localparam logic [15:0] RST_CUR_OFF      = 16'd100;
	localparam logic [15:0] RST_CUR_FS       = 16'd5000;
	localparam logic [31:0] RST_WEIGHTS      = 32'd442119002;
	localparam logic [16:0] RST_ALPHA        = 17'd13107;
	localparam logic [19:0] RST_SLEW         = 20'd8000;

	localparam logic [16:0] ALPHA_MIN     = 17'd655;
	localparam logic [16:0] ALPHA_MAX     = 17'd65536;
	localparam logic [19:0] SLEW_DEFAULT  = 20'd100;
	localparam logic [16:0] SPAN_DEFAULT  = 17'd100;
	localparam int          DT_PROD_W     = 40;

	// Division by one million: drop 2^6 first, then multiply by ceil(2^48 / 15625)
	// and keep the bits above 48, which is exact for any 34-bit dividend.
	localparam int          DT_PRE_SHIFT   = 6;
	localparam int          DT_RECIP_W     = 35;
	localparam logic [34:0] DT_RECIP       = 35'd18014398510;
	localparam int          DT_RECIP_SHIFT = 48;

	typedef enum logic [2:0] {
		REG_ASSIST_RANGE = 3'd0,
		REG_VEL_FS       = 3'd1,
		REG_ACC_FS       = 3'd2,
		REG_CUR_OFF      = 3'd3,
		REG_CUR_FS       = 3'd4,
		REG_WEIGHTS      = 3'd5,
		REG_ALPHA        = 3'd6,
		REG_SLEW         = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] assist_range;
		logic [15:0] vel_fs;
		logic [19:0] acc_fs;
		logic [15:0] cur_off;
		logic [15:0] cur_fs;
		logic [31:0] weights;
		logic [16:0] alpha;
		logic [19:0] slew;
	} cfg_t;

	// One classified request as it waits between front and back.
	typedef struct packed {
		logic [15:0] vmag;
		logic [20:0] amag;
		logic [15:0] cmag;
		logic [19:0] dt;
		logic        fwd;
		logic        hold;
	} item_t;

endpackage

### sv/assist_demand_slew_controller_unit.sv
`timescale 1ns / 1ps
// Top level: configuration registers, front end, queue and back end.
// Sequence: a zero time step request goes from the queue straight to the output state; any
// other request also runs a restoring divider for each of the three ratios, except where a
// ratio saturates (or the current ratio is zero), since that ratio then skips its divider run.
// Flow: the back end takes one request at a time; two more can queue up front, and a
// stalled output holds the back end.
// Reset: arst_n clears smoothed demand and held command to zero, loads register defaults.
module assist_demand_slew_controller_unit #(
	parameter int NORM_FRAC_BITS = adsc_pkg::NORM_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   velocity,
	input  logic signed [20:0]   acceleration,
	input  logic signed [15:0]   motor_current,
	input  logic [19:0]          time_step,
	input  logic                 forward,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          assist_magnitude,
	output logic signed [16:0]   assist_signed
);

	adsc_pkg::cfg_t  cfg_q;
	adsc_pkg::item_t q_item;
	logic            q_valid;
	logic            q_pop;

	// Register writes are masked to each register's width and take effect at the next
	// edge, so they belong in stretches where no request is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.assist_range <= adsc_pkg::RST_ASSIST_RANGE;
			cfg_q.vel_fs       <= adsc_pkg::RST_VEL_FS;
			cfg_q.acc_fs       <= adsc_pkg::RST_ACC_FS;
			cfg_q.cur_off      <= adsc_pkg::RST_CUR_OFF;
			cfg_q.cur_fs       <= adsc_pkg::RST_CUR_FS;
			cfg_q.weights      <= adsc_pkg::RST_WEIGHTS;
			cfg_q.alpha        <= adsc_pkg::RST_ALPHA;
			cfg_q.slew         <= adsc_pkg::RST_SLEW;
		end else if (cfg_we) begin
			case (cfg_index)
				adsc_pkg::REG_ASSIST_RANGE: cfg_q.assist_range <= cfg_data;
				adsc_pkg::REG_VEL_FS:       cfg_q.vel_fs       <= cfg_data[15:0];
				adsc_pkg::REG_ACC_FS:       cfg_q.acc_fs       <= cfg_data[19:0];
				adsc_pkg::REG_CUR_OFF:      cfg_q.cur_off      <= cfg_data[15:0];
				adsc_pkg::REG_CUR_FS:       cfg_q.cur_fs       <= cfg_data[15:0];
				adsc_pkg::REG_WEIGHTS:      cfg_q.weights      <= cfg_data;
				adsc_pkg::REG_ALPHA:        cfg_q.alpha        <= cfg_data[16:0];
				adsc_pkg::REG_SLEW:         cfg_q.slew         <= cfg_data[19:0];
				default: begin
				end
			endcase
		end
	end

	// The front end classifies each request and queues it for the back end.
	adsc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.velocity      (velocity),
		.acceleration  (acceleration),
		.motor_current (motor_current),
		.time_step     (time_step),
		.forward       (forward),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_item        (q_item)
	);

	// The back end runs the arithmetic sequence and owns the output register.
	adsc_back #(
		.NORM_FRAC_BITS (NORM_FRAC_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (q_valid),
		.q_pop            (q_pop),
		.q_item           (q_item),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.assist_magnitude (assist_magnitude),
		.assist_signed    (assist_signed)
	);

endmodule

### sv/adsc_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, takes magnitudes, flags holds, queues them.
module adsc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   velocity,
	input  logic signed [20:0]   acceleration,
	input  logic signed [15:0]   motor_current,
	input  logic [19:0]          time_step,
	input  logic                 forward,
	output logic                 q_valid,
	input  logic                 q_pop,
	output adsc_pkg::item_t      q_item
);

	adsc_pkg::item_t mem_q [2];
	adsc_pkg::item_t new_item;
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	always_comb begin
		new_item.vmag = velocity[15] ? 16'(-velocity) : 16'(velocity);
		new_item.amag = acceleration[20] ? 21'(-acceleration) : 21'(acceleration);
		new_item.cmag = motor_current[15] ? 16'(-motor_current) : 16'(motor_current);
		new_item.dt   = time_step;
		new_item.fwd  = forward;
		new_item.hold = (time_step == 20'd0);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### sv/adsc_back.sv
`timescale 1ns / 1ps
// Back end: normalizes, forms and smooths demand, slew-limits the command.
module adsc_back #(
	parameter int NORM_FRAC_BITS = adsc_pkg::NORM_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adsc_pkg::cfg_t       cfg,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  adsc_pkg::item_t      q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          assist_magnitude,
	output logic signed [16:0]   assist_signed
);

	localparam int F   = NORM_FRAC_BITS;
	localparam int NW  = F + 1;
	localparam int SW  = F + 11;
	localparam int PW  = F + 18;
	localparam int TW  = F + 17;
	localparam int QW  = adsc_pkg::DT_PROD_W;
	localparam int RW  = adsc_pkg::DT_RECIP_W;
	localparam int YW  = QW - adsc_pkg::DT_PRE_SHIFT;
	localparam int YH  = YW / 2;
	localparam logic [NW-1:0] ONE = NW'(1) << F;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_DIV_SET, S_DIV_RUN, S_MD1, S_MD2, S_DEM1, S_DEM2,
		S_SM1, S_SM2, S_TGT, S_PROD, S_CMD, S_OUT
	} state_t;

	localparam logic [1:0] PH_SPD = 2'd0;
	localparam logic [1:0] PH_ACC = 2'd1;
	localparam logic [1:0] PH_EFF = 2'd2;
	localparam logic [1:0] PH_DT  = 2'd3;

	state_t           state_q;
	adsc_pkg::item_t  it_q;
	logic [1:0]       phase_q;
	logic [15:0]      vmin_q, vmax_q, off_q;
	logic [15:0]      vfs_q;
	logic [19:0]      afs_q;
	logic [16:0]      span_q, alpha_q;
	logic [QW-1:0]    dtp_q;
	logic [19:0]      r_q, d_q;
	logic [F-1:0]     qt_q;
	logic [5:0]       cnt_q;
	logic [NW-1:0]    spd_q, acc_q, eff_q, inter_q, dem_q, sm_q;
	logic [20:0]      md_q;
	logic [YH+RW-1:0] mdl_q;
	logic [SW-1:0]    p1_q;
	logic [PW-1:0]    smp_q;
	logic             up_q;
	logic [TW-1:0]    tp_q;
	logic [15:0]      held_q;
	logic             out_valid_q;
	logic [15:0]      mag_q;
	logic signed [16:0] sgn_q;

	// Sanitized configuration.
	logic [15:0]      c_min, c_max_raw, c_max, c_vfs, c_off;
	logic [19:0]      c_afs, c_slew;
	logic [16:0]      c_span, c_alpha;
	// Divider step.
	logic [20:0]      rr;
	logic             ge;
	logic [19:0]      r_nx;
	logic [F-1:0]     qt_nx;
	// Datapath.
	logic [YW-1:0]    dt_y;
	logic [YW+RW-1:0] md_sum;
	logic [SW-1:0]    dem_sum;
	logic [F+2:0]     dem_raw;
	logic [PW-1:0]    sm_prod;
	logic [F+2:0]     sm_up;
	logic [PW:0]      sm_down;
	logic [16:0]      target;
	logic [21:0]      cmd, diff, step;
	logic [15:0]      cmag_off;
	logic             out_free;

	always_comb begin
		c_min     = cfg.assist_range[15:0];
		c_max_raw = cfg.assist_range[31:16];
		c_max     = (c_max_raw < c_min) ? c_min : c_max_raw;
		c_vfs     = (cfg.vel_fs == 16'd0) ? 16'd1 : cfg.vel_fs;
		c_afs     = (cfg.acc_fs == 20'd0) ? 20'd1 : cfg.acc_fs;
		c_off     = cfg.cur_off;
		c_span    = (cfg.cur_fs <= cfg.cur_off) ? adsc_pkg::SPAN_DEFAULT
		            : 17'(cfg.cur_fs - cfg.cur_off);
		c_alpha   = (cfg.alpha < adsc_pkg::ALPHA_MIN) ? adsc_pkg::ALPHA_MIN
		            : (cfg.alpha > adsc_pkg::ALPHA_MAX) ? adsc_pkg::ALPHA_MAX : cfg.alpha;
		c_slew    = (cfg.slew == 20'd0) ? adsc_pkg::SLEW_DEFAULT : cfg.slew;
	end

	// One quotient bit per cycle of a restoring divider.
	always_comb begin
		rr    = {r_q, 1'b0};
		ge    = (rr >= {1'b0, d_q});
		r_nx  = ge ? 20'(rr - {1'b0, d_q}) : rr[19:0];
		qt_nx = {qt_q[F-2:0], ge};
	end

	// Slew budget: the product is split in two halves, low half registered first.
	always_comb begin
		dt_y   = dtp_q[QW-1:adsc_pkg::DT_PRE_SHIFT];
		md_sum = (YW+RW)'(mdl_q)
		       + (((YW+RW)'(dt_y[YW-1:YH]) * (YW+RW)'(adsc_pkg::DT_RECIP)) << YH);
	end

	always_comb begin
		cmag_off = it_q.cmag - off_q;
		dem_sum  = p1_q
		         + SW'(cfg.weights[23:16] * eff_q)
		         + SW'(cfg.weights[31:24] * inter_q);
		dem_raw  = dem_sum[SW-1:8];
		sm_prod  = up_q ? PW'(alpha_q * (dem_q - sm_q)) : PW'(alpha_q * (sm_q - dem_q));
		sm_up    = (F+3)'(sm_q) + (F+3)'(smp_q[PW-1:16]);
		sm_down  = ((PW+1)'(smp_q) + (PW+1)'(65535)) >> 16;
		target   = 17'(vmin_q) + 17'(tp_q >> F);
		cmd      = 22'(held_q);
		if (22'(target) > cmd) begin
			diff = 22'(target) - cmd;
			step = (diff > 22'(md_q)) ? 22'(md_q) : diff;
			cmd  = cmd + step;
		end else begin
			diff = cmd - 22'(target);
			step = (diff > 22'(md_q)) ? 22'(md_q) : diff;
			cmd  = cmd - step;
		end
		if (cmd < 22'(vmin_q)) begin
			cmd = 22'(vmin_q);
		end
		if (cmd > 22'(vmax_q)) begin
			cmd = 22'(vmax_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SPD;
			sm_q        <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q    <= q_item;
						state_q <= q_item.hold ? S_OUT : S_PREP;
					end
				end
				S_PREP: begin
					vmin_q  <= c_min;
					vmax_q  <= c_max;
					vfs_q   <= c_vfs;
					afs_q   <= c_afs;
					off_q   <= c_off;
					span_q  <= c_span;
					alpha_q <= c_alpha;
					dtp_q   <= QW'(c_slew * it_q.dt);
					phase_q <= PH_SPD;
					state_q <= S_DIV_SET;
				end
				S_DIV_SET: begin
					qt_q    <= '0;
					cnt_q   <= 6'(F);
					state_q <= S_DIV_RUN;
					case (phase_q)
						PH_SPD: begin
							r_q <= 20'(it_q.vmag);
							d_q <= 20'(vfs_q);
							if (it_q.vmag >= vfs_q) begin
								spd_q   <= ONE;
								phase_q <= PH_ACC;
								state_q <= S_DIV_SET;
							end
						end
						PH_ACC: begin
							r_q <= it_q.amag[19:0];
							d_q <= afs_q;
							if (it_q.amag >= {1'b0, afs_q}) begin
								acc_q   <= ONE;
								phase_q <= PH_EFF;
								state_q <= S_DIV_SET;
							end
						end
						PH_EFF: begin
							r_q <= 20'(cmag_off);
							d_q <= 20'(span_q);
							if (it_q.cmag <= off_q) begin
								eff_q   <= '0;
								phase_q <= PH_DT;
								state_q <= S_DIV_SET;
							end else if (17'(cmag_off) >= span_q) begin
								eff_q   <= ONE;
								phase_q <= PH_DT;
								state_q <= S_DIV_SET;
							end
						end
						default: begin
							state_q <= S_MD1;
						end
					endcase
				end
				S_DIV_RUN: begin
					r_q   <= r_nx;
					qt_q  <= qt_nx;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						case (phase_q)
							PH_SPD: begin
								spd_q   <= NW'(qt_nx);
								phase_q <= PH_ACC;
								state_q <= S_DIV_SET;
							end
							PH_ACC: begin
								acc_q   <= NW'(qt_nx);
								phase_q <= PH_EFF;
								state_q <= S_DIV_SET;
							end
							PH_EFF: begin
								eff_q   <= NW'(qt_nx);
								phase_q <= PH_DT;
								state_q <= S_DIV_SET;
							end
							default: begin
								state_q <= S_MD1;
							end
						endcase
					end
				end
				S_MD1: begin
					mdl_q   <= (YH+RW)'(dt_y[YH-1:0]) * (YH+RW)'(adsc_pkg::DT_RECIP);
					state_q <= S_MD2;
				end
				S_MD2: begin
					md_q    <= md_sum[adsc_pkg::DT_RECIP_SHIFT +: 21];
					state_q <= S_DEM1;
				end
				S_DEM1: begin
					inter_q <= NW'(((2*NW)'(spd_q) * (2*NW)'(eff_q)) >> F);
					p1_q    <= SW'(cfg.weights[7:0] * spd_q) + SW'(cfg.weights[15:8] * acc_q);
					state_q <= S_DEM2;
				end
				S_DEM2: begin
					dem_q   <= (dem_raw > (F+3)'(ONE)) ? ONE : NW'(dem_raw);
					state_q <= S_SM1;
				end
				S_SM1: begin
					up_q    <= (dem_q >= sm_q);
					state_q <= S_SM2;
				end
				S_SM2: begin
					smp_q   <= sm_prod;
					state_q <= S_TGT;
				end
				S_TGT: begin
					if (up_q) begin
						sm_q <= (sm_up > (F+3)'(ONE)) ? ONE : NW'(sm_up);
					end else if (sm_down >= (PW+1)'(sm_q)) begin
						sm_q <= '0;
					end else begin
						sm_q <= sm_q - NW'(sm_down);
					end
					state_q <= S_PROD;
				end
				S_PROD: begin
					state_q <= S_CMD;
				end
				S_CMD: begin
					held_q  <= cmd[15:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						mag_q       <= held_q;
						sgn_q       <= it_q.fwd ? signed'({1'b0, held_q})
						               : signed'(-{1'b0, held_q});
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The target product uses the freshly smoothed demand.
	always_ff @(posedge clk) begin
		if (state_q == S_PROD) begin
			tp_q <= TW'(sm_q * (vmax_q - vmin_q));
		end
	end

	assign out_valid        = out_valid_q;
	assign assist_magnitude = mag_q;
	assign assist_signed    = sgn_q;

	a_sm_bound: assert property (@(posedge clk) disable iff (!arst_n) sm_q <= ONE)
		else $error("smoothed demand above one");
	a_hold_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.hold) |=> (state_q == S_OUT))
		else $error("hold request did not go straight to output");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_RUN) |-> (cnt_q != 6'd0))
		else $error("divider running with zero count");

endmodule

### tb/assist_demand_slew_controller_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the assist demand slew controller with its own predictor.
module assist_demand_slew_controller_unit_tb;

	localparam int      FRAC       = 16;
	localparam longint  ONE        = 64'd1 << FRAC;
	localparam int      SETTLE     = 160;     // Longer than one full request latency.
	localparam int      IDLE_LIMIT = 6000;    // Cycles without any handshake on either side or register write.
	localparam int      N_RANDOM   = 1200;
	localparam int      N_PHASES   = 6;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] velocity = '0;
	logic signed [20:0] acceleration = '0;
	logic signed [15:0] motor_current = '0;
	logic [19:0]        time_step = '0;
	logic               forward = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        assist_magnitude;
	logic signed [16:0] assist_signed;

	assist_demand_slew_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.velocity(velocity), .acceleration(acceleration), .motor_current(motor_current),
		.time_step(time_step), .forward(forward),
		.out_valid(out_valid), .out_ready(out_ready),
		.assist_magnitude(assist_magnitude), .assist_signed(assist_signed)
	);

	always #2 clk = ~clk;

	// One expected command as it waits for the block to deliver it.
	typedef struct {
		logic [15:0] mag;
		logic [16:0] sgn;
	} command_t;

	command_t    pending_commands[$];
	int          n_errors = 0;
	int          n_requests = 0;
	int          n_commands = 0;
	int          n_holds = 0;
	bit          calm = 1'b0;    // When set, neither side inserts gaps.

	// Mirror of the configuration registers and of the controller state.
	adsc_pkg::cfg_t shadow_cfg;
	longint      smoothed;
	longint      held;

	// Gap lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	function automatic longint norm_ratio(longint num, longint den);
		if (num >= den) return ONE;
		return (num << FRAC) / den;
	endfunction

	// Advances the mirrored state by one request and returns the command it yields.
	function automatic command_t predict_command(longint vel, longint acc, longint cur,
			longint dt, bit fwd);
		command_t c;
		longint vmin, vmax, vfs, afs, off, cfs, alpha, slew;
		longint spd, accn, eff, mag, dem, down, target, max_delta, cmd;
		longint ws, wa, we, wi;
		if (dt != 0) begin
			vmin = shadow_cfg.assist_range[15:0];
			vmax = shadow_cfg.assist_range[31:16];
			if (vmax < vmin) vmax = vmin;
			vfs = (shadow_cfg.vel_fs == 0) ? 1 : shadow_cfg.vel_fs;
			afs = (shadow_cfg.acc_fs == 0) ? 1 : shadow_cfg.acc_fs;
			off = shadow_cfg.cur_off;
			cfs = shadow_cfg.cur_fs;
			if (cfs <= off) cfs = off + 100;
			alpha = shadow_cfg.alpha;
			if (alpha < adsc_pkg::ALPHA_MIN) alpha = adsc_pkg::ALPHA_MIN;
			if (alpha > adsc_pkg::ALPHA_MAX) alpha = adsc_pkg::ALPHA_MAX;
			slew = (shadow_cfg.slew == 0) ? adsc_pkg::SLEW_DEFAULT : shadow_cfg.slew;

			spd  = norm_ratio(vel < 0 ? -vel : vel, vfs);
			accn = norm_ratio(acc < 0 ? -acc : acc, afs);
			mag  = cur < 0 ? -cur : cur;
			eff  = (mag <= off) ? 0 : norm_ratio(mag - off, cfs - off);

			ws = shadow_cfg.weights[7:0];
			wa = shadow_cfg.weights[15:8];
			we = shadow_cfg.weights[23:16];
			wi = shadow_cfg.weights[31:24];
			dem = (ws * spd + wa * accn + we * eff + wi * ((spd * eff) >> FRAC)) >> 8;
			if (dem > ONE) dem = ONE;

			// Rising demand rounds the step down, falling demand rounds it up.
			if (dem >= smoothed) begin
				smoothed += (alpha * (dem - smoothed)) >> 16;
			end else begin
				down = (alpha * (smoothed - dem) + 65535) >> 16;
				smoothed = (down >= smoothed) ? 0 : smoothed - down;
			end
			if (smoothed > ONE) smoothed = ONE;

			target = vmin + ((smoothed * (vmax - vmin)) >> FRAC);
			max_delta = (slew * dt) / 1000000;
			cmd = held;
			if (target > cmd)
				cmd += (target - cmd > max_delta) ? max_delta : target - cmd;
			else
				cmd -= (cmd - target > max_delta) ? max_delta : cmd - target;
			if (cmd < vmin) cmd = vmin;
			if (cmd > vmax) cmd = vmax;
			held = cmd & 16'hFFFF;
		end
		c.mag = held[15:0];
		c.sgn = fwd ? {1'b0, held[15:0]} : -{1'b0, held[15:0]};
		return c;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		n_errors++;
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Presents one request and waits for the block to take it.
	task automatic send_request(longint vel, longint acc, longint cur, longint dt, bit fwd,
			bit fixed, logic [15:0] fixed_mag, logic [16:0] fixed_sgn);
		int gap;
		command_t c;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		velocity <= 16'(vel);
		acceleration <= 21'(acc);
		motor_current <= 16'(cur);
		time_step <= 20'(dt);
		forward <= fwd;
		do @(posedge clk); while (!in_ready);
		c = predict_command(vel, acc, cur, dt, fwd);
		if (fixed) begin
			c.mag = fixed_mag;
			c.sgn = fixed_sgn;
		end
		pending_commands.push_back(c);
		n_requests++;
		if (dt == 0) n_holds++;
	endtask

	// Waits until the block has drained, then writes all eight registers.
	task automatic load_config(adsc_pkg::cfg_t cfg);
		adsc_pkg::reg_idx_t idx;
		logic [31:0] val [8];
		val[0] = cfg.assist_range;
		val[1] = cfg.vel_fs;
		val[2] = cfg.acc_fs;
		val[3] = cfg.cur_off;
		val[4] = cfg.cur_fs;
		val[5] = cfg.weights;
		val[6] = cfg.alpha;
		val[7] = cfg.slew;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_commands.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			idx = adsc_pkg::reg_idx_t'(i);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		shadow_cfg = cfg;
	endtask

	// Random request: mostly inside the full-scale ranges, sometimes the whole field.
	task automatic send_random_request();
		longint vel, acc, cur, dt;
		int r;
		r = $urandom_range(0, 3);
		vel = (r == 0) ? $signed(16'($urandom)) : $signed($urandom_range(0, 600)) - 300;
		r = $urandom_range(0, 3);
		acc = (r == 0) ? $signed(21'($urandom)) : $signed($urandom_range(0, 6000)) - 3000;
		r = $urandom_range(0, 3);
		cur = (r == 0) ? $signed(16'($urandom)) : $signed($urandom_range(0, 12000)) - 6000;
		r = $urandom_range(0, 19);
		if (r == 0) dt = 0;
		else if (r < 5) dt = $urandom_range(1, 200);
		else if (r < 15) dt = $urandom_range(500, 20000);
		else dt = 20'($urandom);
		send_request(vel, acc, cur, dt, $urandom_range(0, 1), 1'b0, '0, '0);
	endtask

	// Directed rows; a result is typed in only where it is obvious (held command
	// still zero right after reset).
	typedef struct {
		int          vel;
		int          acc;
		int          cur;
		int          dt;
		bit          fwd;
		bit          fixed;
		logic [15:0] mag;
		logic [16:0] sgn;
	} stim_row_t;

	stim_row_t directed[] = '{
		'{0, 0, 0, 0, 1'b1, 1'b1, 16'd0, 17'd0},                  // hold after reset
		'{0, 0, 0, 0, 1'b0, 1'b1, 16'd0, 17'd0},                  // hold, reverse
		'{0, 0, 0, 1, 1'b1, 1'b0, 16'd0, 17'd0},                  // step too small to move
		'{32767, 1048575, 32767, 1048575, 1'b1, 1'b0, 16'd0, 17'd0},
		'{-32768, -1048576, -32768, 1048575, 1'b0, 1'b0, 16'd0, 17'd0},
		'{180, 2000, 5000, 1000, 1'b1, 1'b0, 16'd0, 17'd0},       // exactly full scale
		'{179, 1999, 4999, 1000, 1'b0, 1'b0, 16'd0, 17'd0},
		'{-90, 0, 100, 50000, 1'b1, 1'b0, 16'd0, 17'd0},          // current at offset
		'{0, -1000, -101, 50000, 1'b1, 1'b0, 16'd0, 17'd0},       // just above offset
		'{0, 0, 0, 0, 1'b0, 1'b0, 16'd0, 17'd0},                  // hold a moved command
		'{0, 0, 0, 1048575, 1'b1, 1'b0, 16'd0, 17'd0},            // demand falls off
		'{-1, -1, -1, 125, 1'b0, 1'b0, 16'd0, 17'd0}
	};

	// Response side: random back-pressure, and each delivered command is checked.
	int rx_wait = 0;
	always @(posedge clk) begin
		command_t want;
		if (out_valid && out_ready) begin
			n_commands++;
			if (pending_commands.size() == 0) begin
				report_mismatch("unexpected command", assist_magnitude, -1);
			end else begin
				want = pending_commands.pop_front();
				if (assist_magnitude !== want.mag)
					report_mismatch("assist_magnitude", assist_magnitude, want.mag);
				if (assist_signed !== want.sgn)
					report_mismatch("assist_signed", assist_signed, $signed(want.sgn));
			end
		end
		if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			rx_wait = pick_gap();
			out_ready <= (rx_wait == 0);
			if (rx_wait > 0) rx_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: a stuck handshake on either side ends the run.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout with %0d commands outstanding", pending_commands.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		adsc_pkg::cfg_t cfg;
		shadow_cfg = '{adsc_pkg::RST_ASSIST_RANGE, adsc_pkg::RST_VEL_FS, adsc_pkg::RST_ACC_FS,
			adsc_pkg::RST_CUR_OFF, adsc_pkg::RST_CUR_FS, adsc_pkg::RST_WEIGHTS,
			adsc_pkg::RST_ALPHA, adsc_pkg::RST_SLEW};
		smoothed = 0;
		held = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run with the reset configuration.
		foreach (directed[i])
			send_request(directed[i].vel, directed[i].acc, directed[i].cur, directed[i].dt,
				directed[i].fwd, directed[i].fixed, directed[i].mag, directed[i].sgn);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: cfg = shadow_cfg;
				// Widest range; every full scale, alpha and slew at zero.
				1: cfg = '{32'hFFFF_0000, 16'd0, 20'd0, 16'd0, 16'd0, 32'hFFFF_FFFF,
					17'd0, 20'd0};
				// Max below min; weights zero, current full scale below offset, the rest at top end.
				2: cfg = '{32'h0100_0800, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'd1000, 32'd0,
					17'h1FFFF, 20'hFFFFF};
				// Full scale not above offset, alpha exactly one.
				3: cfg = '{32'h0AF0_0096, 16'd90, 20'd500, 16'd3000, 16'd2500, 32'h40806020,
					17'd65536, 20'd50000};
				default: begin
					cfg.assist_range = $urandom;
					if ($urandom_range(0, 1)) cfg.assist_range[31:16] = $urandom_range(2000, 12000);
					if ($urandom_range(0, 1)) cfg.assist_range[15:0] = $urandom_range(0, 1000);
					cfg.vel_fs = $urandom_range(1, 400);
					cfg.acc_fs = $urandom_range(1, 5000);
					cfg.cur_off = $urandom_range(0, 500);
					cfg.cur_fs = $urandom_range(0, 8000);
					cfg.weights = $urandom;
					cfg.alpha = $urandom_range(0, 70000);
					cfg.slew = $urandom_range(0, 300000);
				end
			endcase
			load_config(cfg);
			for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
				if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
				send_random_request();
			end
			calm = 1'b0;
		end
		in_valid <= 1'b0;

		while (pending_commands.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d requests (%0d holds) over %0d register settings, %0d commands checked",
			n_requests, n_holds, N_PHASES, n_commands);
		$display("Mismatches found: %0d", n_errors);
		if (n_errors == 0 && pending_commands.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
